[src/slsa_pkg.sv]
// slsa_pkg: shared types, codes and fixed widths of the slab slot allocator
`default_nettype none

package slsa_pkg;

    // fixed field widths
    localparam int FUNC_W     = 2;
    localparam int IDX_W      = 10;
    localparam int SLOT_W     = 10;
    localparam int STATUS_W   = 2;
    localparam int POOL_W     = 11;
    localparam int POOL_RESET = 1024;

    // shared unit widths and reciprocal scaling
    localparam int UNIT_W   = 24;
    localparam int UNIT_AW  = 10;
    localparam int RECIP_SH = 16;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REINIT = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE        = 2'd3;

    // sequencer states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_A_CHK,
        S_A_RD,
        S_A_SLOT,
        S_F_CHK,
        S_F_DIV,
        S_F_REM,
        S_F_RD,
        S_RESP
    } t_state;

    // shared unit operations
    typedef enum logic [1:0] {
        UOP_NOP,
        UOP_RECIP,
        UOP_MAC,
        UOP_MSUB
    } t_uop;

    // request to the shared unit
    typedef struct packed {
        t_uop               op;
        logic [UNIT_AW-1:0] a;
        logic [UNIT_AW-1:0] b;
    } t_unit_req;

endpackage

`default_nettype wire

[src/slsa_if.sv]
// slsa_if: valid/ready channel interfaces for request and result items
`default_nettype none

interface slsa_in_if import slsa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  slot_index;

    modport source (output valid, output func, output slot_index, input ready);
    modport sink   (input valid, input func, input slot_index, output ready);
endinterface

interface slsa_out_if import slsa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   granted_slot;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output granted_slot, output status, input ready);
    modport sink   (input valid, input granted_slot, input status, output ready);
endinterface

`default_nettype wire

[src/slsa_ram.sv]
// slsa_ram: generic one-write one-read ram with registered read data
`default_nettype none

module slsa_ram #(
    parameter int  WIDTH = 64,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [AW-1:0]        i_waddr,
    input  wire logic [WIDTH-1:0]     i_wdata,
    input  wire logic [AW-1:0]        i_raddr,
    output logic      [WIDTH-1:0]     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

[src/slsa_unit.sv]
// slsa_unit: shared multiply unit for block split, remainder and slot number
`default_nettype none

module slsa_unit import slsa_pkg::*; #(
    parameter int SLOTS_PER_BLOCK = 64
) (
    input  wire logic              i_clk,
    input  wire t_unit_req         i_req,
    output logic      [UNIT_W-1:0] o_y
);
    localparam int RECIP_M = (1 << RECIP_SH) / SLOTS_PER_BLOCK;

    logic [UNIT_W-1:0] w_k;
    logic [UNIT_W-1:0] w_prod;
    logic [UNIT_W-1:0] n_y;
    logic [UNIT_W-1:0] r_y;

    // one multiplier, constant picked by operation
    always_comb begin
        w_k    = (i_req.op == UOP_RECIP) ? UNIT_W'(RECIP_M) : UNIT_W'(SLOTS_PER_BLOCK);
        w_prod = UNIT_W'(i_req.a) * w_k;
        case (i_req.op)
            UOP_RECIP: n_y = w_prod >> RECIP_SH;
            UOP_MAC:   n_y = w_prod + UNIT_W'(i_req.b);
            UOP_MSUB:  n_y = UNIT_W'(i_req.b) - w_prod;
            default:   n_y = '0;
        endcase
    end

    // registered result
    always_ff @(posedge i_clk) begin
        r_y <= n_y;
    end

    assign o_y = r_y;
endmodule

`default_nettype wire

[src/slab_slot_allocator_top.sv]
// slab_slot_allocator_top: bitmap slab slot allocator with free block chain
//
// Request items arrive on i_in (func, slot_index) and each gives exactly one
// result item on o_out (granted_slot, status). i_cfg_we/i_cfg_wdata write
// pool_size, which is taken up at the next reinitialize.
// One item is in work at a time; i_in.ready is high only while idle.
// Allocate checks the head and reads its bitmap and link, then claims the
// lowest free slot, whose number the shared multiply unit forms, or steps
// over a full block along the chain. Free checks the range, splits the index
// into block and bit in the shared unit and reads the bitmap; an index beyond
// the pool goes straight to the result. Reinit writes one bitmap/link row per
// cycle. A spare code goes straight to the result.
// The ram reads are registered, and so is the result of the shared multiply
// unit, which splits the index into block and bit and forms the slot number.
// The result sits in an output register; a stalled receiver holds it there,
// and the block may take the next item meanwhile, finishing it once the
// register is free.
// Reset restores pool_size to 1024 and runs an init pass that clears the
// bitmaps, marking slots beyond the pool as used, and chains the blocks in order; no item is taken then.
`default_nettype none

module slab_slot_allocator_top import slsa_pkg::*; #(
    parameter int SLOTS_PER_BLOCK = 64,
    parameter int NUM_BLOCKS      = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [POOL_W-1:0] i_cfg_wdata,
    slsa_in_if.sink                i_in,
    slsa_out_if.source             o_out
);
    localparam int SBW       = $clog2(SLOTS_PER_BLOCK);
    localparam int BW        = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int LW        = $clog2(NUM_BLOCKS + 1);
    localparam int STW       = $clog2(NUM_BLOCKS + 2);
    localparam int CAP       = NUM_BLOCKS * SLOTS_PER_BLOCK;
    localparam int PMAX      = (CAP > 2047) ? CAP : 2047;
    localparam int PW        = $clog2(PMAX + 1);
    localparam int RESET_SAT = (POOL_RESET > CAP) ? CAP : POOL_RESET;
    localparam logic [SLOTS_PER_BLOCK-1:0] FULL_MASK = '1;

    t_state               r_state, n_state;
    logic [POOL_W-1:0]    r_pool_size, n_pool_size;
    logic [PW-1:0]        r_sat, n_sat;
    logic [PW-1:0]        r_base, n_base;
    logic [LW-1:0]        r_ablk, n_ablk;
    logic [BW-1:0]        r_idx, n_idx;
    logic                 r_from_op, n_from_op;
    logic [BW-1:0]        r_head, n_head;
    logic                 r_hv, n_hv;
    logic [STW-1:0]       r_steps, n_steps;
    logic [IDX_W-1:0]     r_slot_idx, n_slot_idx;
    logic [UNIT_AW-1:0]   r_q, n_q;
    logic [BW-1:0]        r_blk, n_blk;
    logic [SBW-1:0]       r_bit, n_bit;
    logic [SLOT_W-1:0]    r_res_slot, n_res_slot;
    logic [STATUS_W-1:0]  r_res_status, n_res_status;
    logic                 r_out_valid, n_out_valid;
    logic [SLOT_W-1:0]    r_out_slot, n_out_slot;
    logic [STATUS_W-1:0]  r_out_status, n_out_status;

    // ram ports
    logic                       w_bm_we;
    logic [BW-1:0]              w_bm_waddr;
    logic [SLOTS_PER_BLOCK-1:0] w_bm_wdata;
    logic [BW-1:0]              w_bm_raddr;
    logic [SLOTS_PER_BLOCK-1:0] w_bm_rd;
    logic                       w_ln_we;
    logic [BW-1:0]              w_ln_waddr;
    logic [LW-1:0]              w_ln_wdata;
    logic [LW-1:0]              w_ln_rd;

    // shared unit
    t_unit_req                  w_ureq;
    logic [UNIT_W-1:0]          w_uy;

    // helpers
    logic [SLOTS_PER_BLOCK-1:0] w_free;
    logic [SLOTS_PER_BLOCK-1:0] w_low;
    logic [SBW-1:0]             w_ffs_bit;
    logic [PW-1:0]              w_rem_pool;
    logic                       w_active;
    logic                       w_partial;
    logic [SLOTS_PER_BLOCK-1:0] w_init_mask;
    logic                       w_rem_ge;
    logic [UNIT_W-1:0]          w_rem;
    logic [UNIT_AW-1:0]         w_q_c;

    slsa_ram #(
        .WIDTH (SLOTS_PER_BLOCK),
        .DEPTH (NUM_BLOCKS)
    ) u_bitmap_ram (
        .i_clk   (i_clk),
        .i_we    (w_bm_we),
        .i_waddr (w_bm_waddr),
        .i_wdata (w_bm_wdata),
        .i_raddr (w_bm_raddr),
        .o_rdata (w_bm_rd)
    );

    slsa_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_BLOCKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_ln_we),
        .i_waddr (w_ln_waddr),
        .i_wdata (w_ln_wdata),
        .i_raddr (r_head),
        .o_rdata (w_ln_rd)
    );

    slsa_unit #(
        .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK)
    ) u_unit (
        .i_clk (i_clk),
        .i_req (w_ureq),
        .o_y   (w_uy)
    );

    // lowest free slot of the block just read
    always_comb begin
        w_free    = ~w_bm_rd;
        w_low     = w_free & (~w_free + SLOTS_PER_BLOCK'(1));
        w_ffs_bit = '0;
        for (int j = 0; j < SLOTS_PER_BLOCK; j++) begin
            if (w_low[j]) begin
                w_ffs_bit = w_ffs_bit | SBW'(j);
            end
        end
    end

    // row contents during the init pass
    always_comb begin
        w_rem_pool  = r_sat - r_base;
        w_active    = r_base < r_sat;
        w_partial   = w_active && (w_rem_pool < PW'(SLOTS_PER_BLOCK));
        w_init_mask = w_partial ? (FULL_MASK << w_rem_pool[SBW-1:0]) : '0;
    end

    // remainder correction after the reciprocal split
    always_comb begin
        w_rem_ge = w_uy >= UNIT_W'(SLOTS_PER_BLOCK);
        w_rem    = w_rem_ge ? (w_uy - UNIT_W'(SLOTS_PER_BLOCK)) : w_uy;
        w_q_c    = r_q + UNIT_AW'(w_rem_ge);
    end

    // state and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_pool_size <= POOL_W'(POOL_RESET);
            r_sat       <= PW'(RESET_SAT);
            r_base      <= '0;
            r_ablk      <= '0;
            r_idx       <= '0;
            r_from_op   <= 1'b0;
            r_head      <= '0;
            r_hv        <= 1'b0;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pool_size <= n_pool_size;
            r_sat       <= n_sat;
            r_base      <= n_base;
            r_ablk      <= n_ablk;
            r_idx       <= n_idx;
            r_from_op   <= n_from_op;
            r_head      <= n_head;
            r_hv        <= n_hv;
            r_steps     <= n_steps;
            r_out_valid <= n_out_valid;
        end
        r_slot_idx   <= n_slot_idx;
        r_q          <= n_q;
        r_blk        <= n_blk;
        r_bit        <= n_bit;
        r_res_slot   <= n_res_slot;
        r_res_status <= n_res_status;
        r_out_slot   <= n_out_slot;
        r_out_status <= n_out_status;
    end

    // sequencer: next state, ram and unit control
    always_comb begin
        n_state      = r_state;
        n_pool_size  = i_cfg_we ? i_cfg_wdata : r_pool_size;
        n_sat        = r_sat;
        n_base       = r_base;
        n_ablk       = r_ablk;
        n_idx        = r_idx;
        n_from_op    = r_from_op;
        n_head       = r_head;
        n_hv         = r_hv;
        n_steps      = r_steps;
        n_slot_idx   = r_slot_idx;
        n_q          = r_q;
        n_blk        = r_blk;
        n_bit        = r_bit;
        n_res_slot   = r_res_slot;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_slot   = r_out_slot;
        n_out_status = r_out_status;

        w_bm_we    = 1'b0;
        w_bm_waddr = r_head;
        w_bm_wdata = w_bm_rd;
        w_bm_raddr = r_head;
        w_ln_we    = 1'b0;
        w_ln_waddr = r_idx;
        w_ln_wdata = LW'(r_idx) + LW'(1);
        w_ureq     = '{op: UOP_NOP, a: '0, b: '0};

        case (r_state)
            // one bitmap and link row per cycle
            S_INIT: begin
                w_bm_we    = 1'b1;
                w_bm_waddr = r_idx;
                w_bm_wdata = w_init_mask;
                w_ln_we    = 1'b1;
                n_base     = r_base + PW'(SLOTS_PER_BLOCK);
                n_ablk     = r_ablk + LW'(w_active);
                n_idx      = r_idx + BW'(1);
                if (r_idx == BW'(NUM_BLOCKS - 1)) begin
                    n_head       = '0;
                    n_hv         = n_ablk != '0;
                    n_res_slot   = '0;
                    n_res_status = ST_OK;
                    n_state      = r_from_op ? S_RESP : S_IDLE;
                end
            end

            // take a new item
            S_IDLE: begin
                if (i_in.valid) begin
                    n_slot_idx   = i_in.slot_index;
                    n_steps      = '0;
                    n_res_slot   = '0;
                    n_res_status = ST_OK;
                    case (i_in.func)
                        FUNC_ALLOC: n_state = S_A_CHK;
                        FUNC_FREE:  n_state = S_F_CHK;
                        FUNC_REINIT: begin
                            n_sat     = (PW'(r_pool_size) > PW'(CAP)) ?
                                        PW'(CAP) : PW'(r_pool_size);
                            n_base    = '0;
                            n_ablk    = '0;
                            n_idx     = '0;
                            n_from_op = 1'b1;
                            n_state   = S_INIT;
                        end
                        default:    n_state = S_RESP;
                    endcase
                end
            end

            // allocate: check head, read its bitmap and link
            S_A_CHK: begin
                if (!r_hv || (LW'(r_head) >= r_ablk)) begin
                    n_hv         = 1'b0;
                    n_res_status = ST_NO_SLOT;
                    n_state      = S_RESP;
                end else begin
                    n_state = S_A_RD;
                end
            end

            // allocate: claim lowest free slot or step along the chain
            S_A_RD: begin
                if (w_free != '0) begin
                    w_bm_we    = 1'b1;
                    w_bm_waddr = r_head;
                    w_bm_wdata = w_bm_rd | w_low;
                    w_ureq     = '{op: UOP_MAC, a: UNIT_AW'(r_head), b: UNIT_AW'(w_ffs_bit)};
                    n_state    = S_A_SLOT;
                end else begin
                    if (w_ln_rd < r_ablk) begin
                        n_head = w_ln_rd[BW-1:0];
                    end else begin
                        n_hv = 1'b0;
                    end
                    if (r_steps == STW'(NUM_BLOCKS)) begin
                        n_res_status = ST_NO_SLOT;
                        n_state      = S_RESP;
                    end else begin
                        n_steps = r_steps + STW'(1);
                        n_state = S_A_CHK;
                    end
                end
            end

            // allocate: slot number from the unit
            S_A_SLOT: begin
                n_res_slot   = w_uy[SLOT_W-1:0];
                n_res_status = ST_OK;
                n_state      = S_RESP;
            end

            // free: range check, start the block split
            S_F_CHK: begin
                if (PW'(r_slot_idx) >= r_sat) begin
                    n_res_status = ST_RANGE;
                    n_state      = S_RESP;
                end else begin
                    w_ureq  = '{op: UOP_RECIP, a: UNIT_AW'(r_slot_idx), b: '0};
                    n_state = S_F_DIV;
                end
            end

            // free: estimated block, ask for the remainder
            S_F_DIV: begin
                n_q     = w_uy[UNIT_AW-1:0];
                w_ureq  = '{op: UOP_MSUB, a: w_uy[UNIT_AW-1:0], b: UNIT_AW'(r_slot_idx)};
                n_state = S_F_REM;
            end

            // free: corrected block and bit, read the bitmap
            S_F_REM: begin
                n_blk      = w_q_c[BW-1:0];
                n_bit      = w_rem[SBW-1:0];
                w_bm_raddr = w_q_c[BW-1:0];
                n_state    = S_F_RD;
            end

            // free: clear the bit, push a block that was full
            S_F_RD: begin
                if (!w_bm_rd[r_bit]) begin
                    n_res_status = ST_ALREADY_FREE;
                end else begin
                    w_bm_we    = 1'b1;
                    w_bm_waddr = r_blk;
                    w_bm_wdata = w_bm_rd & ~(SLOTS_PER_BLOCK'(1) << r_bit);
                    if ((w_bm_rd == FULL_MASK) && !(r_hv && (r_head == r_blk))) begin
                        w_ln_we    = 1'b1;
                        w_ln_waddr = r_blk;
                        w_ln_wdata = r_hv ? LW'(r_head) : r_ablk;
                        n_head     = r_blk;
                        n_hv       = 1'b1;
                    end
                    n_res_status = ST_OK;
                end
                n_state = S_RESP;
            end

            // hand the result to the output register
            S_RESP: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_slot   = r_res_slot;
                    n_out_status = r_res_status;
                    n_from_op    = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // channel outputs
    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.granted_slot = r_out_slot;
    assign o_out.status       = r_out_status;
endmodule

`default_nettype wire

[src/slsa_checker.sv]
// slsa_checker: port-level assertions for the slot allocator, bound to the top
`default_nettype none

module slsa_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready
);
    logic [1:0] r_outstanding;
    logic [1:0] n_outstanding;

    // items accepted whose result is not yet taken
    always_comb begin
        n_outstanding = r_outstanding
                        + 2'(i_in_valid && i_in_ready)
                        - 2'(i_out_valid && i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= n_outstanding;
        end
    end

    // a result held back by the receiver stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("new item taken while one is in work");

    // no result without an item behind it
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_outstanding != 2'd0)
        else $error("result item with no item outstanding");

    // at most one waiting result and one item in work
    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding != 2'd3)
        else $error("outstanding item count out of bounds");
endmodule

bind slab_slot_allocator_top slsa_checker u_slsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready)
);

`default_nettype wire
